>>> rtl/sfmc_pkg.sv
// ----------------------------------------------------------------------------
// sfmc_pkg
// Shared types and constants of the split-flap module controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sfmc_pkg;

	localparam int CARD_COUNT = 52;
	localparam int POS_W      = 6;
	localparam int FLIP_W     = $clog2(CARD_COUNT + 1);

	localparam logic [POS_W-1:0] LAST_POS       = POS_W'(CARD_COUNT - 1);
	localparam logic [POS_W:0]   CARD_COUNT_EXT = (POS_W + 1)'(CARD_COUNT);

	// frame bytes
	localparam logic [7:0] BYTE_START = 8'hFF;
	localparam logic [7:0] ADDR_BCAST = 8'hFF;
	localparam logic [7:0] CMD_REL    = 8'h2B;
	localparam logic [7:0] CMD_ABS    = 8'h63;
	localparam logic [7:0] CMD_HOME   = 8'h68;
	localparam logic [7:0] CMD_REPORT = 8'h67;
	localparam logic [7:0] CMD_DETECT = 8'h64;

	// item kinds
	localparam logic OP_BYTE   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// register indexes
	localparam logic REG_ADDR = 1'b0;
	localparam logic REG_POL  = 1'b1;

	typedef enum logic [1:0] {
		PH_START,
		PH_ADDR,
		PH_CMD,
		PH_ARG
	} phase_t;

	typedef enum logic [1:0] {
		PEND_NONE,
		PEND_REL,
		PEND_ABS
	} pend_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_FLIP,
		MODE_HOME,
		MODE_DETECT
	} mode_t;

endpackage

`default_nettype wire

>>> rtl/split_flap_module_controller.sv
// ----------------------------------------------------------------------------
// split_flap_module_controller
// Frame parser and motion control for one split-flap module.
// ----------------------------------------------------------------------------
// One item per clock cycle while out_stall is low: an item is captured in an
// input register and processed once the result register can take it; then
// the parser and motion state are updated and one result is written to the
// result register. The result register decouples the sides: a new item is
// taken while a result waits.
// Registers: module_address at byte address 0, card_polarity at 4.
`default_nettype none

module split_flap_module_controller (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [2:0]                  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	// items in
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        op,
	input  wire logic [7:0]                  data_byte,
	input  wire logic                        card_pin,
	input  wire logic                        home_pin,
	// results out
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             motor_on,
	output logic                             busy_res,
	output logic [sfmc_pkg::POS_W-1:0]       card_index,
	output logic                             reply_valid,
	output logic [7:0]                       reply_byte,
	output logic                             byte_dropped
);

	// configuration registers
	logic [4:0] module_address_q;
	logic       card_polarity_q;

	// input stage
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] data_byte_s1;
	logic       card_pin_s1;
	logic       home_pin_s1;

	// result stage
	logic                         out_valid_s2;
	logic                         busy_s2;
	logic [sfmc_pkg::POS_W-1:0]   card_index_s2;
	logic                         reply_valid_s2;
	logic [7:0]                   reply_byte_s2;
	logic                         byte_dropped_s2;

	// controller state
	sfmc_pkg::phase_t             phase_q, phase_d;
	logic                         bcast_q, bcast_d;
	sfmc_pkg::pend_t              pend_q, pend_d;
	logic [sfmc_pkg::POS_W-1:0]   card_pos_q, card_pos_d;
	sfmc_pkg::mode_t              mode_q, mode_d;
	logic [7:0]                   cards_left_q, cards_left_d;
	logic                         seen_inactive_q, seen_inactive_d;
	logic                         home_left_q, home_left_d;
	logic                         home_found_q, home_found_d;
	logic [sfmc_pkg::FLIP_W-1:0]  flipped_q, flipped_d;
	logic                         first_sample_q, first_sample_d;

	logic       advance;
	logic       cfg_write;
	logic       card_act;
	logic       home_act;
	logic       reply_valid_d;
	logic [7:0] reply_byte_d;
	logic       byte_dropped_d;

	assign advance   = valid_s1 && (!out_valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	assign card_act = card_polarity_q ? card_pin_s1 : !card_pin_s1;
	assign home_act = !home_pin_s1;

	always_comb begin
		unique case (paddr[2])
			sfmc_pkg::REG_ADDR: prdata = {27'd0, module_address_q};
			sfmc_pkg::REG_POL:  prdata = {31'd0, card_polarity_q};
			default:            prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_address_q <= '0;
			card_polarity_q  <= 1'b0;
		end else if (cfg_write) begin
			unique case (paddr[2])
				sfmc_pkg::REG_ADDR: module_address_q <= pwdata[4:0];
				sfmc_pkg::REG_POL:  card_polarity_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		logic                        counted;
		logic                        hl;
		logic [7:0]                  pos8;
		logic [7:0]                  flip_n;
		logic [sfmc_pkg::POS_W-1:0]  pos_next;

		phase_d         = phase_q;
		bcast_d         = bcast_q;
		pend_d          = pend_q;
		card_pos_d      = card_pos_q;
		mode_d          = mode_q;
		cards_left_d    = cards_left_q;
		seen_inactive_d = seen_inactive_q;
		home_left_d     = home_left_q;
		home_found_d    = home_found_q;
		flipped_d       = flipped_q;
		first_sample_d  = first_sample_q;

		counted  = 1'b0;
		hl       = home_left_q;
		pos8     = {2'b00, card_pos_q};
		flip_n   = 8'd0;
		pos_next = (card_pos_q == sfmc_pkg::LAST_POS) ? '0 : card_pos_q + 1'b1;

		if (op_s1 == sfmc_pkg::OP_SAMPLE) begin
			if (mode_q == sfmc_pkg::MODE_HOME) begin
				if (!home_left_q) begin
					if (!home_act)
						home_left_d = 1'b1;
				end else if (card_act && home_act) begin
					card_pos_d = '0;
					mode_d     = sfmc_pkg::MODE_IDLE;
				end
			end else if (mode_q != sfmc_pkg::MODE_IDLE) begin
				// first sample also records whether home was already left
				if (first_sample_q) begin
					first_sample_d = 1'b0;
					hl             = !home_act;
				end
				if (!card_act) begin
					seen_inactive_d = 1'b1;
				end else if (seen_inactive_q) begin
					seen_inactive_d = 1'b0;
					counted         = 1'b1;
				end
				if (counted && mode_q == sfmc_pkg::MODE_FLIP) begin
					if (!hl && !home_act)
						hl = 1'b1;
					card_pos_d   = pos_next;
					cards_left_d = cards_left_q - 8'd1;
					if (cards_left_q == 8'd1)
						mode_d = sfmc_pkg::MODE_IDLE;
				end else if (counted && mode_q == sfmc_pkg::MODE_DETECT) begin
					flipped_d = flipped_q + 1'b1;
					if (!hl && !home_act)
						hl = 1'b1;
					if (hl && !home_found_q && home_act) begin
						card_pos_d   = sfmc_pkg::POS_W'(sfmc_pkg::CARD_COUNT)
						             - sfmc_pkg::POS_W'(flipped_d);
						home_found_d = 1'b1;
					end
					if (flipped_d >= sfmc_pkg::FLIP_W'(sfmc_pkg::CARD_COUNT))
						mode_d = sfmc_pkg::MODE_IDLE;
				end
				home_left_d = hl;
			end
		end else if (mode_q == sfmc_pkg::MODE_IDLE) begin
			unique case (phase_q)
				sfmc_pkg::PH_START: begin
					if (data_byte_s1 == sfmc_pkg::BYTE_START)
						phase_d = sfmc_pkg::PH_ADDR;
				end
				sfmc_pkg::PH_ADDR: begin
					bcast_d = (data_byte_s1 == sfmc_pkg::ADDR_BCAST);
					phase_d = (bcast_d || data_byte_s1 == {3'b000, module_address_q})
					        ? sfmc_pkg::PH_CMD : sfmc_pkg::PH_START;
				end
				sfmc_pkg::PH_CMD: begin
					phase_d = sfmc_pkg::PH_START;
					unique case (data_byte_s1)
						sfmc_pkg::CMD_REL: begin
							pend_d  = sfmc_pkg::PEND_REL;
							phase_d = sfmc_pkg::PH_ARG;
						end
						sfmc_pkg::CMD_ABS: begin
							pend_d  = sfmc_pkg::PEND_ABS;
							phase_d = sfmc_pkg::PH_ARG;
						end
						sfmc_pkg::CMD_HOME: begin
							mode_d      = sfmc_pkg::MODE_HOME;
							home_left_d = 1'b0;
						end
						sfmc_pkg::CMD_DETECT: begin
							mode_d          = sfmc_pkg::MODE_DETECT;
							flipped_d       = '0;
							home_found_d    = 1'b0;
							seen_inactive_d = 1'b0;
							first_sample_d  = 1'b1;
						end
						default: ;
					endcase
				end
				sfmc_pkg::PH_ARG: begin
					phase_d = sfmc_pkg::PH_START;
					pend_d  = sfmc_pkg::PEND_NONE;
					if (pend_q == sfmc_pkg::PEND_REL)
						flip_n = data_byte_s1;
					else if (pend_q == sfmc_pkg::PEND_ABS && data_byte_s1 != pos8)
						// target below position wraps once around the drum
						flip_n = (data_byte_s1 >= pos8) ? data_byte_s1 - pos8
						       : data_byte_s1 + 8'(sfmc_pkg::CARD_COUNT) - pos8;
					if (flip_n != 8'd0) begin
						mode_d          = sfmc_pkg::MODE_FLIP;
						cards_left_d    = flip_n;
						seen_inactive_d = 1'b0;
						first_sample_d  = 1'b1;
					end
				end
				default: phase_d = sfmc_pkg::PH_START;
			endcase
		end
	end

	// result fields
	always_comb begin
		reply_valid_d  = (op_s1 == sfmc_pkg::OP_BYTE) && (mode_q == sfmc_pkg::MODE_IDLE)
		              && (phase_q == sfmc_pkg::PH_CMD) && (data_byte_s1 == sfmc_pkg::CMD_REPORT)
		              && !bcast_q;
		reply_byte_d   = reply_valid_d ? {2'b00, card_pos_q} : 8'd0;
		byte_dropped_d = (op_s1 == sfmc_pkg::OP_BYTE) && (mode_q != sfmc_pkg::MODE_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1        <= op;
			data_byte_s1 <= data_byte;
			card_pin_s1  <= card_pin;
			home_pin_s1  <= home_pin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= sfmc_pkg::PH_START;
			bcast_q         <= 1'b0;
			pend_q          <= sfmc_pkg::PEND_NONE;
			card_pos_q      <= '0;
			mode_q          <= sfmc_pkg::MODE_IDLE;
			cards_left_q    <= '0;
			seen_inactive_q <= 1'b0;
			home_left_q     <= 1'b0;
			home_found_q    <= 1'b0;
			flipped_q       <= '0;
			first_sample_q  <= 1'b0;
		end else if (advance) begin
			phase_q         <= phase_d;
			bcast_q         <= bcast_d;
			pend_q          <= pend_d;
			card_pos_q      <= card_pos_d;
			mode_q          <= mode_d;
			cards_left_q    <= cards_left_d;
			seen_inactive_q <= seen_inactive_d;
			home_left_q     <= home_left_d;
			home_found_q    <= home_found_d;
			flipped_q       <= flipped_d;
			first_sample_q  <= first_sample_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			busy_s2         <= (mode_d != sfmc_pkg::MODE_IDLE);
			card_index_s2   <= card_pos_d;
			reply_valid_s2  <= reply_valid_d;
			reply_byte_s2   <= reply_byte_d;
			byte_dropped_s2 <= byte_dropped_d;
		end
	end

	assign out_valid    = out_valid_s2;
	assign motor_on     = busy_s2;
	assign busy_res     = busy_s2;
	assign card_index   = card_index_s2;
	assign reply_valid  = reply_valid_s2;
	assign reply_byte   = reply_byte_s2;
	assign byte_dropped = byte_dropped_s2;

	// checks

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, card_pos_q} < sfmc_pkg::CARD_COUNT_EXT)
		else $error("card position beyond card count");

	a_flip_has_cards: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == sfmc_pkg::MODE_FLIP |-> cards_left_q != 8'd0)
		else $error("flip running with no cards left");

	a_reply_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && reply_valid_s2 |-> !busy_s2 && !byte_dropped_s2)
		else $error("reply issued while busy or with a dropped byte");

	a_idle_sample_no_move: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == sfmc_pkg::OP_SAMPLE && mode_q == sfmc_pkg::MODE_IDLE
		|=> $stable(card_pos_q) && mode_q == sfmc_pkg::MODE_IDLE)
		else $error("sample while idle changed position or mode");

endmodule

`default_nettype wire

>>> dv/sfmc_flap_checker.sv
// ----------------------------------------------------------------------------
// sfmc_flap_checker
// Watches the item and result channels and the register port of the
// split-flap module controller. Keeps its own copy of the frame parser and
// motion state, predicts one result per accepted item and compares each
// delivered result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sfmc_flap_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	input  logic [31:0]                prdata,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic                       op,
	input  logic [7:0]                 data_byte,
	input  logic                       card_pin,
	input  logic                       home_pin,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic                       motor_on,
	input  logic                       busy_res,
	input  logic [sfmc_pkg::POS_W-1:0] card_index,
	input  logic                       reply_valid,
	input  logic [7:0]                 reply_byte,
	input  logic                       byte_dropped,
	output int                         fail_count,
	output int                         expected_left,
	output logic                       motion_busy
);

	import sfmc_pkg::*;

	typedef struct packed {
		logic             motor;
		logic             busy;
		logic [POS_W-1:0] index;
		logic             reply;
		logic [7:0]       reply_data;
		logic             dropped;
	} flap_result_t;

	// register copies
	logic [4:0] cfg_address = '0;
	logic       cfg_pol     = 1'b0;

	// parser and motion state
	phase_t           frame_phase  = PH_START;
	logic             frame_bcast  = 1'b0;
	pend_t            pend_cmd     = PEND_NONE;
	logic [POS_W-1:0] position     = '0;
	mode_t            mode         = MODE_IDLE;
	logic [7:0]       flips_left   = '0;
	logic             card_clear   = 1'b0;
	logic             off_home     = 1'b0;
	logic             home_seen    = 1'b0;
	logic [5:0]       detect_count = '0;
	logic             first_look   = 1'b0;

	flap_result_t pending_flap_results[$];
	flap_result_t want;
	int           mismatches  = 0;
	int           outstanding = 0;
	logic [31:0]  reg_value;

	assign fail_count    = mismatches;
	assign expected_left = outstanding;
	assign motion_busy   = (mode != MODE_IDLE);

	function automatic void check_field(input string name, input int unsigned exp_v,
			input int unsigned got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			mismatches++;
		end
	endfunction

	function automatic void begin_flip(input logic [7:0] count);
		if (count != 8'd0) begin
			mode       = MODE_FLIP;
			flips_left = count;
			card_clear = 1'b0;
			first_look = 1'b1;
		end
	endfunction

	function automatic flap_result_t advance_module(input logic kind, input logic [7:0] b,
			input logic cp, input logic hp);
		flap_result_t r;
		logic         card_act;
		logic         home_act;
		logic         counted;
		int           n;
		r        = '0;
		card_act = cfg_pol ? cp : !cp;
		home_act = !hp;
		counted  = 1'b0;
		if (kind == OP_SAMPLE) begin
			if (mode == MODE_HOME) begin
				// homing ends on card and home together, once home was left
				if (!off_home) begin
					if (!home_act)
						off_home = 1'b1;
				end else if (card_act && home_act) begin
					position = '0;
					mode     = MODE_IDLE;
				end
			end else if (mode != MODE_IDLE) begin
				if (first_look) begin
					first_look = 1'b0;
					off_home   = !home_act;
				end
				if (!card_act) begin
					card_clear = 1'b1;
				end else if (card_clear) begin
					card_clear = 1'b0;
					counted    = 1'b1;
				end
				if (counted && mode == MODE_FLIP) begin
					if (!home_act)
						off_home = 1'b1;
					position   = (int'(position) + 1 >= CARD_COUNT) ? '0 : position + 1'b1;
					flips_left = flips_left - 8'd1;
					if (flips_left == 8'd0)
						mode = MODE_IDLE;
				end else if (counted && mode == MODE_DETECT) begin
					detect_count = detect_count + 6'd1;
					if (!home_act)
						off_home = 1'b1;
					if (off_home && !home_seen && home_act) begin
						position  = POS_W'(CARD_COUNT - int'(detect_count));
						home_seen = 1'b1;
					end
					if (int'(detect_count) >= CARD_COUNT)
						mode = MODE_IDLE;
				end
			end
		end else if (mode != MODE_IDLE) begin
			r.dropped = 1'b1;
		end else begin
			case (frame_phase)
				PH_START: begin
					if (b == BYTE_START)
						frame_phase = PH_ADDR;
				end
				PH_ADDR: begin
					frame_bcast = (b == ADDR_BCAST);
					frame_phase = (frame_bcast || b == {3'b000, cfg_address}) ? PH_CMD : PH_START;
				end
				PH_CMD: begin
					frame_phase = PH_START;
					if (b == CMD_REL) begin
						pend_cmd    = PEND_REL;
						frame_phase = PH_ARG;
					end else if (b == CMD_ABS) begin
						pend_cmd    = PEND_ABS;
						frame_phase = PH_ARG;
					end else if (b == CMD_HOME) begin
						mode     = MODE_HOME;
						off_home = 1'b0;
					end else if (b == CMD_REPORT) begin
						if (!frame_bcast) begin
							r.reply      = 1'b1;
							r.reply_data = {2'b00, position};
						end
					end else if (b == CMD_DETECT) begin
						mode         = MODE_DETECT;
						detect_count = '0;
						home_seen    = 1'b0;
						card_clear   = 1'b0;
						first_look   = 1'b1;
					end
				end
				default: begin
					frame_phase = PH_START;
					if (pend_cmd == PEND_REL) begin
						begin_flip(b);
					end else if (pend_cmd == PEND_ABS && b != {2'b00, position}) begin
						// targets below the position go round the drum
						n = (b >= {2'b00, position}) ? int'(b) - int'(position)
							: int'(b) + CARD_COUNT - int'(position);
						begin_flip(n[7:0]);
					end
					pend_cmd = PEND_NONE;
				end
			endcase
		end
		r.motor = (mode != MODE_IDLE);
		r.busy  = r.motor;
		r.index = position;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_address  = '0;
			cfg_pol      = 1'b0;
			frame_phase  = PH_START;
			frame_bcast  = 1'b0;
			pend_cmd     = PEND_NONE;
			position     = '0;
			mode         = MODE_IDLE;
			flips_left   = '0;
			card_clear   = 1'b0;
			off_home     = 1'b0;
			home_seen    = 1'b0;
			detect_count = '0;
			first_look   = 1'b0;
			pending_flap_results.delete();
			outstanding  = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_ADDR)
						cfg_address = pwdata[4:0];
					else
						cfg_pol = pwdata[0];
				end else begin
					reg_value = (paddr[2] == REG_ADDR) ? {27'd0, cfg_address} : {31'd0, cfg_pol};
					check_field("prdata", reg_value, prdata);
				end
			end
			if (out_valid && !out_stall) begin
				if (pending_flap_results.size() == 0) begin
					$error("result delivered with no item outstanding");
					mismatches++;
				end else begin
					want = pending_flap_results.pop_front();
					check_field("motor_on", 32'(want.motor), 32'(motor_on));
					check_field("busy_res", 32'(want.busy), 32'(busy_res));
					check_field("card_index", 32'(want.index), 32'(card_index));
					check_field("reply_valid", 32'(want.reply), 32'(reply_valid));
					check_field("reply_byte", 32'(want.reply_data), 32'(reply_byte));
					check_field("byte_dropped", 32'(want.dropped), 32'(byte_dropped));
				end
			end
			if (in_valid && !in_stall)
				pending_flap_results.push_back(advance_module(op, data_byte, card_pin, home_pin));
			outstanding = pending_flap_results.size();
		end
	end

endmodule

>>> dv/tb_split_flap_module_controller.sv
// ----------------------------------------------------------------------------
// tb_split_flap_module_controller
// Drives command frames and sensor sample trains into the split-flap module
// controller under changing addresses, sensor polarities and handshake
// pressure; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_split_flap_module_controller;

	import sfmc_pkg::*;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef enum logic [1:0] {
		HOME_RANDOM,
		HOME_CLEAR,
		HOME_BLOCKED
	} home_style_t;

	localparam int ITEM_TARGET  = 850;
	localparam int PHASE_ITEMS  = 100;
	localparam int RUN_LIMIT    = 20 * 400000;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [2:0]        paddr        = '0;
	logic [31:0]       pwdata       = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic              op           = OP_BYTE;
	logic [7:0]        data_byte    = '0;
	logic              card_pin     = 1'b0;
	logic              home_pin     = 1'b1;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic              motor_on;
	logic              busy_res;
	logic [POS_W-1:0]  card_index;
	logic              reply_valid;
	logic [7:0]        reply_byte;
	logic              byte_dropped;
	int                fail_count;
	int                expected_left;
	logic              motion_busy;

	idle_mode_t        idle_mode    = IDLE_NONE;
	logic [4:0]        mod_addr     = '0;
	logic              card_pol     = 1'b0;
	int                items_done   = 0;

	split_flap_module_controller dut (.*);

	sfmc_flap_checker u_checker (.*);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		case (idle_mode)
			IDLE_RECEIVER: out_stall <= ($urandom_range(0, 99) < 84);
			IDLE_BOTH:     out_stall <= ($urandom_range(0, 99) < 19);
			default:       out_stall <= 1'b0;
		endcase
	end

	initial begin
		#(RUN_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	function automatic bit sender_waits();
		case (idle_mode)
			IDLE_SENDER: return ($urandom_range(0, 99) < 84);
			IDLE_BOTH:   return ($urandom_range(0, 99) < 19);
			default:     return 1'b0;
		endcase
	endfunction

	// entered and left at a falling edge; the item is held until taken
	task automatic send_item(input logic kind, input logic [7:0] b, input logic cp,
			input logic hp, input bit tally);
		while (sender_waits()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		op        <= kind;
		data_byte <= b;
		card_pin  <= cp;
		home_pin  <= hp;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (tally)
			items_done++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(OP_BYTE, b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
	endtask

	task automatic send_frame(input logic [7:0] addr_b, input logic [7:0] cmd);
		send_byte(BYTE_START);
		send_byte(addr_b);
		send_byte(cmd);
	endtask

	// sample train for as long as the predicted motion runs, with stray bytes
	task automatic drive_motion(input home_style_t style);
		logic card_on;
		logic hp;
		card_on = 1'b0;
		while (motion_busy) begin
			if ($urandom_range(0, 24) == 0) begin
				send_item(OP_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'b0);
			end else begin
				if ($urandom_range(0, 4) != 0)
					card_on = !card_on;
				case (style)
					HOME_CLEAR:   hp = 1'b1;
					HOME_BLOCKED: hp = 1'b0;
					default:      hp = ($urandom_range(0, 2) != 0);
				endcase
				send_item(OP_SAMPLE, 8'($urandom_range(0, 255)),
					card_on ? card_pol : !card_pol, hp, 1'b1);
			end
		end
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] a, input logic [31:0] d);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= a;
		pwdata  <= d;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
	endtask

	task automatic configure(input logic [4:0] a, input logic p);
		mod_addr = a;
		card_pol = p;
		apb_access(1'b1, {REG_ADDR, 2'b00}, {27'd0, a});
		apb_access(1'b1, {REG_POL, 2'b00}, {31'd0, p});
		apb_access(1'b0, {REG_ADDR, 2'b00}, $urandom);
		apb_access(1'b0, {REG_POL, 2'b00}, $urandom);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_left != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_scenario();
		int          pick;
		int          r;
		logic [7:0]  addr_b;
		logic [7:0]  b;
		home_style_t style;
		pick   = $urandom_range(0, 99);
		addr_b = ($urandom_range(0, 3) == 0) ? ADDR_BCAST : {3'b000, mod_addr};
		style  = home_style_t'($urandom_range(0, 2));
		if (pick < 30) begin
			r = $urandom_range(0, 29);
			send_frame(addr_b, CMD_REL);
			send_byte((r == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 8)));
		end else if (pick < 55) begin
			r = $urandom_range(0, 9);
			send_frame(addr_b, CMD_ABS);
			if (r < 7)
				send_byte(8'($urandom_range(0, CARD_COUNT - 1)));
			else if (r < 9)
				send_byte(8'($urandom_range(CARD_COUNT, 63)));
			else
				send_byte(8'($urandom_range(0, 255)));
		end else if (pick < 65) begin
			// homing needs home to come and go
			style = HOME_RANDOM;
			send_frame(addr_b, CMD_HOME);
		end else if (pick < 78) begin
			send_frame(addr_b, CMD_REPORT);
		end else if (pick < 83) begin
			send_frame(addr_b, CMD_DETECT);
		end else if (pick < 90) begin
			do b = 8'($urandom_range(0, 255));
			while (b == ADDR_BCAST || b == {3'b000, mod_addr});
			send_frame(b, ($urandom_range(0, 1) == 0) ? CMD_REPORT : CMD_REL);
		end else if (pick < 95) begin
			do b = 8'($urandom_range(0, 255));
			while (b == CMD_REL || b == CMD_ABS || b == CMD_HOME || b == CMD_REPORT
				|| b == CMD_DETECT);
			send_frame(addr_b, b);
		end else begin
			repeat ($urandom_range(1, 5)) begin
				if ($urandom_range(0, 1) == 0)
					send_byte(8'($urandom_range(0, 255)));
				else
					send_item(OP_SAMPLE, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
			end
		end
		drive_motion(style);
	endtask

	initial begin
		int         phase;
		int         next_switch;
		logic [7:0] wrong_addr;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		configure(5'd0, 1'b0);

		// directed: ignored sample, report, broadcast report, foreign address,
		// unknown command, empty flips, busy drop, far target, blind detect
		wrong_addr = {3'b000, mod_addr} + 8'd1;
		send_item(OP_SAMPLE, 8'h00, 1'b1, 1'b0, 1'b0);
		send_frame({3'b000, mod_addr}, CMD_REPORT);
		send_frame(ADDR_BCAST, CMD_REPORT);
		send_frame(wrong_addr, CMD_REPORT);
		send_frame({3'b000, mod_addr}, 8'h00);
		send_frame({3'b000, mod_addr}, CMD_REL);
		send_byte(8'd0);
		send_frame({3'b000, mod_addr}, CMD_ABS);
		send_byte(8'd0);
		send_frame({3'b000, mod_addr}, CMD_REL);
		send_byte(8'd1);
		send_item(OP_BYTE, 8'hFF, 1'b1, 1'b1, 1'b0);
		drive_motion(HOME_RANDOM);
		send_frame(ADDR_BCAST, CMD_ABS);
		send_byte(8'(CARD_COUNT + 1));
		drive_motion(HOME_RANDOM);
		send_frame({3'b000, mod_addr}, CMD_DETECT);
		drive_motion(HOME_CLEAR);

		phase       = 0;
		next_switch = items_done;
		while (items_done < ITEM_TARGET) begin
			if (items_done >= next_switch) begin
				drain_results();
				phase++;
				case (phase % 6)
					0: configure(5'd0, 1'b0);
					1: configure(5'd31, 1'b1);
					2: configure(5'($urandom_range(0, 31)), 1'b0);
					3: configure(5'd0, 1'b1);
					4: configure(5'($urandom_range(0, 31)), 1'b1);
					default: configure(5'd31, 1'b0);
				endcase
				idle_mode   = idle_mode_t'(phase % 4);
				next_switch = items_done + PHASE_ITEMS;
			end
			run_scenario();
		end

		drain_results();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && expected_left == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
